// File: hdl/symmetric_block3_spmv_top_macros.svh
// assertion macros for the symmetric block spmv design
`ifndef SYMMETRIC_BLOCK3_SPMV_TOP_MACROS_SVH
`define SYMMETRIC_BLOCK3_SPMV_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define SBS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sbs assertion failed");

// next-cycle implication, checked outside reset
`define SBS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sbs assertion failed");

`endif

// File: hdl/sbs_pkg.sv
// types and codes shared by the symmetric block spmv files
package sbs_pkg;
  typedef logic signed [31:0] word_t;
  typedef logic [2:0][31:0] vec_t;
  typedef logic [2:0][2:0][31:0] mat_t;

  typedef logic [1:0] kind_t;
  localparam kind_t REQ_LOAD  = 2'd0;
  localparam kind_t REQ_APPLY = 2'd1;
  localparam kind_t REQ_READ  = 2'd2;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_BAD = 1'b1;
endpackage

// File: hdl/sbs_if.sv
// channel interfaces: request, response and configuration write
interface sbs_req_if;
  import sbs_pkg::*;
  logic  valid;
  logic  ready;
  kind_t req_type;
  logic [7:0] row_block;
  logic [7:0] col_block;
  word_t a00, a01, a02, a10, a11, a12, a20, a21, a22;
  modport src (output valid, req_type, row_block, col_block,
               a00, a01, a02, a10, a11, a12, a20, a21, a22, input ready);
  modport snk (input valid, req_type, row_block, col_block,
               a00, a01, a02, a10, a11, a12, a20, a21, a22, output ready);
endinterface

interface sbs_rsp_if;
  import sbs_pkg::*;
  logic  valid;
  logic  ready;
  logic  status;
  word_t out_x, out_y, out_z;
  modport src (output valid, status, out_x, out_y, out_z, input ready);
  modport snk (input valid, status, out_x, out_y, out_z, output ready);
endinterface

interface sbs_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] block_count;
  modport src (output valid, block_count, input ready);
  modport snk (input valid, block_count, output ready);
endinterface

// File: hdl/symmetric_block3_spmv_top.sv
// symmetric 3x3 block sparse matrix-vector multiply, top level
// usage:
//   req_i  : load (x[row] <= a00,a01,a02), apply (block at row,col of an upper
//            triangle stream; row > col is transposed and swapped), read
//            (returns y[row] and clears it). one response per request.
//   rsp_o  : status 0 done / 1 ignored (index at or above block_count, or an
//            unknown kind); out_x/y/z carry y on a good read, else zero.
//   cfg_i  : block_count write, taken at any cycle; write it only when idle.
// sequencing: a load or rejected request goes straight to the response,
//   a read passes the read-and-clear state, a diagonal apply a product and an
//   accumulate state, an off-diagonal apply a second product and accumulate
//   pass for the column. requests are not overlapped: the result memory (one
//   read port, one write port) is read, then written per updated row, and
//   the nine-lane product stage is reused for the row and column updates.
// a one-entry request buffer takes the next request while the current one
// is at work, and the response register lets work finish while the receiver
// stalls; a full response register holds the sequencer in its last state.
// reset: block_count = 256, all result entries read as zero (per-entry valid
// flops, no clearing pass), input vector entries undefined until loaded.
module symmetric_block3_spmv_top #(
  parameter int MAX_BLOCKS = 256,
  parameter int FRAC_BITS  = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  sbs_req_if.snk req_i,
  sbs_rsp_if.src rsp_o,
  sbs_cfg_if.snk cfg_i
);
  import sbs_pkg::*;
  `include "symmetric_block3_spmv_top_macros.svh"

  localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_RDR  = 7'b0000010,
    ST_MUL1 = 7'b0000100,
    ST_ACC1 = 7'b0001000,
    ST_MUL2 = 7'b0010000,
    ST_ACC2 = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_e;

  // configuration
  logic [8:0] bc_q;
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q <= 9'd256;
    end else if (cfg_i.valid) begin
      bc_q <= cfg_i.block_count;
    end
  end

  function automatic logic in_range(input logic [7:0] idx, input logic [8:0] bc);
    return ({1'b0, idx} < bc) && (32'(idx) < MAX_BLOCKS);
  endfunction

  // request buffer
  logic       hold_q;
  kind_t      h_kind_q;
  logic [7:0] h_row_q, h_col_q;
  mat_t       h_a_q;
  logic       hold_clr;

  assign req_i.ready = !hold_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else if (req_i.valid && req_i.ready) begin
      hold_q <= 1'b1;
    end else if (hold_clr) begin
      hold_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      h_kind_q <= req_i.req_type;
      h_row_q  <= req_i.row_block;
      h_col_q  <= req_i.col_block;
      h_a_q    <= {{req_i.a22, req_i.a21, req_i.a20},
                   {req_i.a12, req_i.a11, req_i.a10},
                   {req_i.a02, req_i.a01, req_i.a00}};
    end
  end

  // work registers
  state_e     state_q, state_d;
  logic [7:0] r_q, r_d, c_q, c_d;
  mat_t       m_q, m_d;
  logic       st_q, st_d;
  vec_t       res_q, res_d;

  // memories: input vector (two read ports), result vector with valid flops
  vec_t   xmem [MAX_BLOCKS];
  vec_t   ymem [MAX_BLOCKS];
  logic   yvalid_q [MAX_BLOCKS];
  logic   x_we, x_re, y_we, y_re, y_clr;
  logic [AW-1:0] x_waddr, xr_addr, xc_addr, y_waddr, y_raddr;
  vec_t   x_wdata, y_wdata;
  vec_t   xr_rd_q, xc_rd_q, y_rd_q;
  logic   yv_rd_q;
  vec_t   y_eff;

  always_ff @(posedge clk_i) begin
    if (x_we) begin
      xmem[x_waddr] <= x_wdata;
    end
    if (x_re) begin
      xr_rd_q <= xmem[xr_addr];
      xc_rd_q <= xmem[xc_addr];
    end
    if (y_we) begin
      ymem[y_waddr] <= y_wdata;
    end
    if (y_re) begin
      y_rd_q <= ymem[y_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_BLOCKS; k++) begin
        yvalid_q[k] <= 1'b0;
      end
      yv_rd_q <= 1'b0;
    end else begin
      if (y_we) begin
        yvalid_q[y_waddr] <= 1'b1;
      end else if (y_clr) begin
        yvalid_q[y_waddr] <= 1'b0;
      end
      if (y_re) begin
        yv_rd_q <= yvalid_q[y_raddr];
      end
    end
  end

  assign y_eff = yv_rd_q ? y_rd_q : '0;

  // product lanes: pass one uses m and x[c], pass two uses m transposed and x[r]
  logic [2:0][2:0][63:0] prod_q;
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        logic signed [63:0] p;
        logic [31:0] cf, xv;
        cf = (state_q == ST_MUL2) ? m_q[j][i] : m_q[i][j];
        xv = (state_q == ST_MUL2) ? xr_rd_q[j] : xc_rd_q[j];
        p  = $signed(cf) * $signed(xv);
        prod_q[i][j] <= p >>> FRAC_BITS;
      end
    end
  end

  // accumulate with saturation
  vec_t acc_sum;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [65:0] s;
      s = $signed({{34{y_eff[i][31]}}, y_eff[i]})
        + $signed({{2{prod_q[i][0][63]}}, prod_q[i][0]})
        + $signed({{2{prod_q[i][1][63]}}, prod_q[i][1]})
        + $signed({{2{prod_q[i][2][63]}}, prod_q[i][2]});
      if (s > SAT_MAX) begin
        acc_sum[i] = 32'h7FFF_FFFF;
      end else if (s < SAT_MIN) begin
        acc_sum[i] = 32'h8000_0000;
      end else begin
        acc_sum[i] = s[31:0];
      end
    end
  end

  // sequencer
  logic       rsp_valid_q;
  logic       rsp_st_q;
  vec_t       rsp_data_q;
  logic       rsp_load;
  logic       r_ok, c_ok, swap;

  assign r_ok = in_range(h_row_q, bc_q);
  assign c_ok = in_range(h_col_q, bc_q);
  assign swap = h_row_q > h_col_q;

  always_comb begin
    state_d  = state_q;
    r_d      = r_q;
    c_d      = c_q;
    m_d      = m_q;
    st_d     = st_q;
    res_d    = res_q;
    hold_clr = 1'b0;
    rsp_load = 1'b0;
    x_we     = 1'b0;
    x_re     = 1'b0;
    y_we     = 1'b0;
    y_re     = 1'b0;
    y_clr    = 1'b0;
    x_waddr  = AW'(h_row_q);
    x_wdata  = h_a_q[0];
    xr_addr  = AW'(r_q);
    xc_addr  = AW'(c_q);
    y_raddr  = AW'(r_q);
    y_waddr  = AW'(r_q);
    y_wdata  = acc_sum;
    unique case (state_q)
      ST_IDLE: begin
        if (hold_q) begin
          hold_clr = 1'b1;
          st_d     = ST_BAD;
          res_d    = '0;
          state_d  = ST_DONE;
          r_d      = swap ? h_col_q : h_row_q;
          c_d      = swap ? h_row_q : h_col_q;
          for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
              m_d[i][j] = swap ? h_a_q[j][i] : h_a_q[i][j];
            end
          end
          case (h_kind_q)
            REQ_LOAD: begin
              if (r_ok) begin
                x_we = 1'b1;
                st_d = ST_OK;
              end
            end
            REQ_APPLY: begin
              if (r_ok && c_ok) begin
                x_re    = 1'b1;
                y_re    = 1'b1;
                xr_addr = AW'(r_d);
                xc_addr = AW'(c_d);
                y_raddr = AW'(r_d);
                st_d    = ST_OK;
                state_d = ST_MUL1;
              end
            end
            REQ_READ: begin
              if (r_ok) begin
                y_re    = 1'b1;
                y_raddr = AW'(h_row_q);
                r_d     = h_row_q;
                st_d    = ST_OK;
                state_d = ST_RDR;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RDR: begin
        res_d   = y_eff;
        y_clr   = 1'b1;
        state_d = ST_DONE;
      end
      ST_MUL1: state_d = ST_ACC1;
      ST_ACC1: begin
        y_we = 1'b1;
        if (r_q == c_q) begin
          state_d = ST_DONE;
        end else begin
          y_re    = 1'b1;
          y_raddr = AW'(c_q);
          state_d = ST_MUL2;
        end
      end
      ST_MUL2: state_d = ST_ACC2;
      ST_ACC2: begin
        y_we    = 1'b1;
        y_waddr = AW'(c_q);
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q   <= r_d;
    c_q   <= c_d;
    m_q   <= m_d;
    st_q  <= st_d;
    res_q <= res_d;
  end

  // response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_st_q   <= st_q;
      rsp_data_q <= res_q;
    end
  end

  assign rsp_o.valid  = rsp_valid_q;
  assign rsp_o.status = rsp_st_q;
  assign rsp_o.out_x  = rsp_data_q[0];
  assign rsp_o.out_y  = rsp_data_q[1];
  assign rsp_o.out_z  = rsp_data_q[2];

  // checks
  `SBS_ASSERT_IMP(a_norm_order, state_q == ST_MUL1, r_q <= c_q)
  `SBS_ASSERT_NXT(a_diag_single, (state_q == ST_ACC1) && (r_q == c_q), state_q == ST_DONE)
  `SBS_ASSERT_IMP(a_no_rw_clash, y_we && y_re, y_waddr != y_raddr)
  `SBS_ASSERT_IMP(a_bad_zero, rsp_valid_q && rsp_st_q,
    (rsp_data_q[0] == 32'd0) && (rsp_data_q[1] == 32'd0) && (rsp_data_q[2] == 32'd0))
endmodule

// File: tb/tb.sv
// self-checking testbench for the symmetric 3x3 block sparse matrix-vector multiply
`timescale 1ns / 100ps

module tb;
  import sbs_pkg::*;

  localparam kind_t REQ_UNKNOWN = 2'd3;   // reserved kind, must be rejected
  localparam int    IDLE_LIMIT  = 4000;   // cycles without any transfer
  localparam int    DRAIN_WAIT  = 20;     // extra wait once everything has drained

  typedef struct packed {
    kind_t      kind;
    logic [7:0] row;
    logic [7:0] col;
    mat_t       a;      // a[r][c]; load uses a[0][0..2]
  } req_item_t;

  typedef struct packed {
    logic  status;
    word_t x;
    word_t y;
    word_t z;
  } rsp_item_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // request, response and block_count write channels
  sbs_req_if req_bus ();
  sbs_rsp_if rsp_bus ();
  sbs_cfg_if cfg_bus ();

  req_item_t  drv_item  = '0;
  logic       drv_valid = 1'b0;
  logic       rsp_rdy   = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [8:0] cfg_value = '0;

  assign req_bus.valid     = drv_valid;
  assign req_bus.req_type  = drv_item.kind;
  assign req_bus.row_block = drv_item.row;
  assign req_bus.col_block = drv_item.col;
  assign req_bus.a00 = drv_item.a[0][0];
  assign req_bus.a01 = drv_item.a[0][1];
  assign req_bus.a02 = drv_item.a[0][2];
  assign req_bus.a10 = drv_item.a[1][0];
  assign req_bus.a11 = drv_item.a[1][1];
  assign req_bus.a12 = drv_item.a[1][2];
  assign req_bus.a20 = drv_item.a[2][0];
  assign req_bus.a21 = drv_item.a[2][1];
  assign req_bus.a22 = drv_item.a[2][2];
  assign rsp_bus.ready     = rsp_rdy;
  assign cfg_bus.valid       = cfg_valid;
  assign cfg_bus.block_count = cfg_value;

  symmetric_block3_spmv_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus),
    .cfg_i  (cfg_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // shadow of the block: block_count, x store and y accumulators
  // ---------------------------------------------------------------------
  logic [8:0] model_count = 9'd256;
  word_t      x_store [256][3];
  word_t      y_acc   [256][3];

  req_item_t  pending_reqs [$];   // stimulus not yet handed to the driver
  rsp_item_t  expected_rsps [$];  // predicted responses, oldest first

  int  err_count  = 0;
  bit  quiet_mode = 1'b0;         // no idling on either side when set
  bit  xfer_seen;

  function automatic bit model_in_range(logic [7:0] idx);
    return idx < model_count;
  endfunction

  // y + sum of floor(m*x / 2^16), saturated to 32 bits
  function automatic word_t sat_mac(word_t acc, word_t m0, word_t m1, word_t m2,
                                    word_t x0, word_t x1, word_t x2);
    longint sum;
    sum = longint'(acc);
    sum += (longint'(m0) * longint'(x0)) >>> 16;
    sum += (longint'(m1) * longint'(x1)) >>> 16;
    sum += (longint'(m2) * longint'(x2)) >>> 16;
    if (sum > 64'sd2147483647)  return 32'sh7fffffff;
    if (sum < -64'sd2147483648) return 32'sh80000000;
    return word_t'(sum);
  endfunction

  // apply the accepted request to the shadow and queue its response
  function automatic void predict_spmv(req_item_t it);
    rsp_item_t  rsp;
    logic [7:0] r, c;
    word_t      m [3][3];
    r   = it.row;
    c   = it.col;
    rsp = '{status: ST_BAD, x: '0, y: '0, z: '0};
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        m[i][j] = it.a[i][j];
    case (it.kind)
      REQ_LOAD: if (model_in_range(r)) begin
        for (int j = 0; j < 3; j++) x_store[r][j] = m[0][j];
        rsp.status = ST_OK;
      end
      REQ_APPLY: if (model_in_range(r) && model_in_range(c)) begin
        // lower-triangle block: transpose and swap into the upper triangle
        if (r > c) begin
          r = it.col;
          c = it.row;
          for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
              m[i][j] = it.a[j][i];
        end
        for (int i = 0; i < 3; i++)
          y_acc[r][i] = sat_mac(y_acc[r][i], m[i][0], m[i][1], m[i][2],
                                x_store[c][0], x_store[c][1], x_store[c][2]);
        if (r != c)
          for (int i = 0; i < 3; i++)
            y_acc[c][i] = sat_mac(y_acc[c][i], m[0][i], m[1][i], m[2][i],
                                  x_store[r][0], x_store[r][1], x_store[r][2]);
        rsp.status = ST_OK;
      end
      REQ_READ: if (model_in_range(r)) begin
        rsp.x = y_acc[r][0];
        rsp.y = y_acc[r][1];
        rsp.z = y_acc[r][2];
        for (int j = 0; j < 3; j++) y_acc[r][j] = '0;
        rsp.status = ST_OK;
      end
      default: ;
    endcase
    expected_rsps.insert(expected_rsps.size(), rsp);
  endfunction

  // mostly no gap, some short ones, a few long ones
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(99);
    if (quiet_mode || pick < 60) return 0;
    if (pick < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // ---------------------------------------------------------------------
  // request driver: takes the next item from the pending queue
  // ---------------------------------------------------------------------
  int req_gap = 0;

  always @(posedge clk_i) begin : req_driver
    bit took;
    if (rst_ni) begin
      took = drv_valid && req_bus.ready;
      if (took) begin
        predict_spmv(drv_item);
        req_gap = gap_len();
      end
      if (!drv_valid || took) begin
        if (req_gap > 0) begin
          req_gap--;
          drv_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          drv_item  <= pending_reqs.pop_front();
          drv_valid <= 1'b1;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // response monitor with random back-pressure
  // ---------------------------------------------------------------------
  int rsp_stall = 0;

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      err_count++;
      if (err_count <= 10)
        $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk_i) begin : rsp_monitor
    rsp_item_t exp_r;
    if (rst_ni) begin
      if (rsp_bus.valid && rsp_rdy) begin
        if (expected_rsps.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t: response transfer with nothing expected", $realtime);
        end else begin
          exp_r = expected_rsps.pop_front();
          check_field("status", 32'(exp_r.status), 32'(rsp_bus.status));
          check_field("out_x", exp_r.x, rsp_bus.out_x);
          check_field("out_y", exp_r.y, rsp_bus.out_y);
          check_field("out_z", exp_r.z, rsp_bus.out_z);
        end
      end
      if (rsp_stall > 0) begin
        rsp_stall--;
        rsp_rdy <= 1'b0;
      end else begin
        rsp_rdy <= 1'b1;
        if ($urandom_range(3) == 0) rsp_stall = gap_len();
      end
    end
  end

  // watchdog: too long without any transfer on any channel
  int idle_cycles = 0;

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      xfer_seen = (drv_valid && req_bus.ready) || (rsp_bus.valid && rsp_rdy) ||
                  (cfg_valid && cfg_bus.ready);
      idle_cycles = xfer_seen ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // stimulus generation; tracks which x entries have been loaded so that
  // no apply ever reads an unwritten x entry
  // ---------------------------------------------------------------------
  logic [8:0] gen_count = 9'd256;
  bit         gen_loaded [256];

  function automatic bit gen_in_range(logic [7:0] idx);
    return idx < gen_count;
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(9))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return '0;
      3, 4:    return word_t'($urandom);
      5:       return word_t'(32'h0001_0000 << $urandom_range(14));
      default: return word_t'($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  function automatic mat_t rand_block();
    mat_t m;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        m[i][j] = rand_word();
    return m;
  endfunction

  // queue one request, keeping apply legal with respect to loaded entries
  function automatic void push_req(kind_t kind, logic [7:0] row, logic [7:0] col, mat_t a);
    req_item_t it;
    if (kind == REQ_APPLY && gen_in_range(row) && gen_in_range(col)) begin
      if (!gen_loaded[row] || !gen_loaded[col]) begin
        row  = gen_loaded[row] ? col : row;
        kind = REQ_LOAD;
      end
    end
    if (kind == REQ_LOAD && gen_in_range(row)) gen_loaded[row] = 1'b1;
    it = '{kind: kind, row: row, col: col, a: a};
    pending_reqs.insert(pending_reqs.size(), it);
  endfunction

  // mostly in-range indices, sometimes anywhere in the 8-bit space
  function automatic logic [7:0] pick_index();
    int span;
    span = (gen_count > 256) ? 256 : int'(gen_count);
    if (span == 0 || $urandom_range(11) == 0) return 8'($urandom_range(255));
    return 8'($urandom_range(span - 1));
  endfunction

  function automatic void push_random();
    int         pick;
    logic [7:0] r, c;
    pick = $urandom_range(99);
    r    = pick_index();
    c    = ($urandom_range(7) == 0) ? r : pick_index();
    if (pick < 35)      push_req(REQ_LOAD, r, c, rand_block());
    else if (pick < 78) push_req(REQ_APPLY, r, c, rand_block());
    else if (pick < 96) push_req(REQ_READ, r, c, rand_block());
    else                push_req(REQ_UNKNOWN, r, c, rand_block());
  endfunction

  // wait until the block has drained everything, then settle for DRAIN_WAIT
  task automatic wait_idle();
    while (pending_reqs.size() != 0 || drv_valid || expected_rsps.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_count(logic [8:0] value);
    cfg_valid <= 1'b1;
    cfg_value <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    model_count = value;
    gen_count   = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(int n, logic [8:0] count);
    write_count(count);
    quiet_mode = ($urandom_range(3) == 0);
    for (int k = 0; k < n; k++) push_random();
    wait_idle();
  endtask

  initial begin : stimulus
    mat_t extreme_pos, extreme_neg, unit_m;
    for (int i = 0; i < 256; i++) begin
      gen_loaded[i] = 1'b0;
      for (int j = 0; j < 3; j++) begin
        x_store[i][j] = '0;
        y_acc[i][j]   = '0;
      end
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        extreme_pos[i][j] = 32'sh7fffffff;
        extreme_neg[i][j] = 32'sh80000000;
        unit_m[i][j]      = (i == j) ? 32'sh0001_0000 : 32'sh0000_8000 * (i + j);
      end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: loads at both ends, saturating products, both triangles,
    // diagonal, read-and-clear twice, unknown kind
    write_count(9'd256);
    push_req(REQ_LOAD, 8'd0, 8'd0, extreme_pos);
    push_req(REQ_LOAD, 8'd255, 8'd0, extreme_neg);
    push_req(REQ_LOAD, 8'd1, 8'd0, unit_m);
    push_req(REQ_APPLY, 8'd0, 8'd255, extreme_pos);
    push_req(REQ_APPLY, 8'd255, 8'd0, extreme_neg);
    push_req(REQ_APPLY, 8'd0, 8'd0, extreme_pos);
    push_req(REQ_APPLY, 8'd1, 8'd1, unit_m);
    push_req(REQ_APPLY, 8'd1, 8'd0, unit_m);
    push_req(REQ_APPLY, 8'd0, 8'd1, extreme_neg);
    push_req(REQ_READ, 8'd0, 8'd0, '0);
    push_req(REQ_READ, 8'd0, 8'd0, '0);
    push_req(REQ_READ, 8'd255, 8'd7, '0);
    push_req(REQ_READ, 8'd1, 8'd0, '0);
    push_req(REQ_READ, 8'd77, 8'd0, '0);
    push_req(REQ_UNKNOWN, 8'd3, 8'd4, extreme_pos);
    wait_idle();

    // block_count of one and zero
    write_count(9'd1);
    push_req(REQ_LOAD, 8'd1, 8'd0, unit_m);
    push_req(REQ_APPLY, 8'd0, 8'd1, unit_m);
    push_req(REQ_APPLY, 8'd0, 8'd0, unit_m);
    push_req(REQ_READ, 8'd0, 8'd0, '0);
    push_req(REQ_READ, 8'd1, 8'd0, '0);
    wait_idle();
    write_count(9'd0);
    push_req(REQ_LOAD, 8'd0, 8'd0, unit_m);
    push_req(REQ_APPLY, 8'd0, 8'd0, unit_m);
    push_req(REQ_READ, 8'd0, 8'd0, '0);
    wait_idle();

    // random phases over a spread of block counts
    run_random(40, 9'd0);
    run_random(300, 9'd511);
    run_random(250, 9'd4);
    run_random(300, 9'd300);
    run_random(250, 9'd17);
    run_random(300, 9'd256);
    run_random(250, 9'd1);

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/sbs_pkg.sv
hdl/sbs_if.sv
hdl/symmetric_block3_spmv_top.sv
tb/tb.sv
